// ===== sv/gillespie_speciation_step_top_macros.svh =====
// Assertion macros for the Gillespie speciation step checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef GILLESPIE_SPECIATION_STEP_TOP_MACROS_SVH
`define GILLESPIE_SPECIATION_STEP_TOP_MACROS_SVH

// same-cycle implication
`define GSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gss check failed");

// next-cycle implication
`define GSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gss check failed");

`endif

// ===== sv/gss_pkg.sv =====
// Shared types, constants and op codes for the Gillespie speciation step.
// No dependencies.
`default_nettype none
package gss_pkg;

    localparam int NUM_POPS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [18:0] ABUND_MAX  = 19'h7FFFF;
    localparam logic [31:0] WAIT_RESET = 32'h0001_0000;
    localparam logic [31:0] IMM_RESET  = 32'h0001_0000;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_BIRTH = 3'd0;
    localparam logic [2:0] REG_DEATH = 3'd1;
    localparam logic [2:0] REG_EMIG  = 3'd2;
    localparam logic [2:0] REG_SPEC  = 3'd3;
    localparam logic [2:0] REG_IMM   = 3'd4;
    localparam logic [2:0] REG_WAIT  = 3'd5;
    localparam logic [2:0] REG_SETB  = 3'd6;
    localparam logic [2:0] REG_SCALE = 3'd7;

    // event kinds
    localparam logic [2:0] KIND_EMIG  = 3'd0;
    localparam logic [2:0] KIND_BIRTH = 3'd1;
    localparam logic [2:0] KIND_DEATH = 3'd2;
    localparam logic [2:0] KIND_SPEC  = 3'd3;
    localparam logic [2:0] KIND_IMM   = 3'd4;

    // datapath ops
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_RESTART   = 5'd2;
    localparam logic [4:0] OP_HALTED    = 5'd3;
    localparam logic [4:0] OP_WALK_INIT = 5'd4;
    localparam logic [4:0] OP_WALK      = 5'd5;
    localparam logic [4:0] OP_ZERO_SOJ  = 5'd6;
    localparam logic [4:0] OP_TGT0      = 5'd7;
    localparam logic [4:0] OP_TGT1      = 5'd8;
    localparam logic [4:0] OP_TGT2      = 5'd9;
    localparam logic [4:0] OP_DIV_SOJ   = 5'd10;
    localparam logic [4:0] OP_DIV_SETB  = 5'd11;
    localparam logic [4:0] OP_DIV       = 5'd12;
    localparam logic [4:0] OP_ADV       = 5'd13;
    localparam logic [4:0] OP_EVT       = 5'd14;
    localparam logic [4:0] OP_SETB      = 5'd15;
    localparam logic [4:0] OP_FIN       = 5'd16;
    localparam logic [4:0] OP_SUM_INIT  = 5'd17;
    localparam logic [4:0] OP_SUM       = 5'd18;
    localparam logic [4:0] OP_OUT       = 5'd19;

    typedef struct packed {
        logic        command;
        logic [31:0] event_draw;
        logic [31:0] exp_draw;
        logic [2:0]  target_draw;
    } t_in_item;

    typedef struct packed {
        logic [18:0] total_abundance;
        logic [31:0] sojourn_time;
        logic [2:0]  event_kind;
        logic [2:0]  event_population;
        logic        full_speciation;
        logic        ignored;
    } t_out_item;

    typedef struct packed {
        logic [31:0] birth_rate;
        logic [31:0] death_rate;
        logic [31:0] emigration_rate;
        logic [31:0] speciation_rate;
        logic [31:0] immigration_rate;
        logic [31:0] initial_wait;
        logic [31:0] setback;
        logic        setback_by_count;
    } t_cfg;

    typedef struct packed {
        logic [4:0] op;
        logic       sel_mode;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic halted;
        logic walk_done;
        logic tot_zero;
        logic div_done;
        logic need_sdiv;
        logic sum_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== sv/gss_ctrl.sv =====
// Sequencer for the Gillespie speciation step: walks the datapath through one event.
// Depends on gss_pkg.
`default_nettype none
module gss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gss_pkg::t_dp_sts i_sts,
    output gss_pkg::t_dp_cmd o_cmd
);
    import gss_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_TOT    = 5'd2;
    localparam logic [4:0] S_TZ     = 5'd3;
    localparam logic [4:0] S_TGT1   = 5'd4;
    localparam logic [4:0] S_TGT2   = 5'd5;
    localparam logic [4:0] S_SELI   = 5'd6;
    localparam logic [4:0] S_SEL    = 5'd7;
    localparam logic [4:0] S_DIVI   = 5'd8;
    localparam logic [4:0] S_DIV    = 5'd9;
    localparam logic [4:0] S_ADV    = 5'd10;
    localparam logic [4:0] S_EVT    = 5'd11;
    localparam logic [4:0] S_CHK    = 5'd12;
    localparam logic [4:0] S_SDIV   = 5'd13;
    localparam logic [4:0] S_SETB   = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;
    localparam logic [4:0] S_SUMI   = 5'd16;
    localparam logic [4:0] S_SUM    = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.sel_mode = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.restart) begin
                    o_cmd.op = OP_RESTART;
                    n_state  = S_SUMI;
                end else if (i_sts.halted) begin
                    o_cmd.op = OP_HALTED;
                    n_state  = S_SUMI;
                end else begin
                    o_cmd.op = OP_WALK_INIT;
                    n_state  = S_TOT;
                end
            end
            S_TOT: begin
                o_cmd.op = OP_WALK;
                if (i_sts.walk_done) n_state = S_TZ;
            end
            S_TZ: begin
                if (i_sts.tot_zero) begin
                    o_cmd.op = OP_ZERO_SOJ;
                    n_state  = S_ADV;
                end else begin
                    o_cmd.op = OP_TGT0;
                    n_state  = S_TGT1;
                end
            end
            S_TGT1: begin
                o_cmd.op = OP_TGT1;
                n_state  = S_TGT2;
            end
            S_TGT2: begin
                o_cmd.op = OP_TGT2;
                n_state  = S_SELI;
            end
            S_SELI: begin
                o_cmd.op       = OP_WALK_INIT;
                o_cmd.sel_mode = 1'b1;
                n_state        = S_SEL;
            end
            S_SEL: begin
                o_cmd.op = OP_WALK;
                if (i_sts.walk_done) n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.op = OP_DIV_SOJ;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) n_state = S_ADV;
            end
            S_ADV: begin
                o_cmd.op = OP_ADV;
                n_state  = S_EVT;
            end
            S_EVT: begin
                o_cmd.op = OP_EVT;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.need_sdiv) begin
                    o_cmd.op = OP_DIV_SETB;
                    n_state  = S_SDIV;
                end else begin
                    n_state  = S_SETB;
                end
            end
            S_SDIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) n_state = S_SETB;
            end
            S_SETB: begin
                o_cmd.op = OP_SETB;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_SUMI;
            end
            S_SUMI: begin
                o_cmd.op = OP_SUM_INIT;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_sts.sum_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== sv/gss_dp.sv =====
// Datapath for the Gillespie speciation step: population state, shared multiplier,
// weight walker, restoring divider and result register. Depends on gss_pkg.
`default_nettype none
module gss_dp #(
    parameter int NUM_POPS   = gss_pkg::NUM_POPS_DEF,
    parameter int COUNT_BITS = gss_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gss_pkg::t_cfg      i_cfg,
    input  gss_pkg::t_in_item  i_in_item,
    input  gss_pkg::t_dp_cmd   i_cmd,
    input  logic               i_out_stall,
    output gss_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output gss_pkg::t_out_item o_out_item
);
    import gss_pkg::*;

    localparam int              PW        = (NUM_POPS > 1) ? $clog2(NUM_POPS) : 1;
    localparam logic [PW-1:0]   LAST_POP  = PW'(NUM_POPS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [5:0]      DIV_STEPS = 6'd48;

    // population state
    logic [COUNT_BITS-1:0] r_cnt   [NUM_POPS];
    logic [31:0]           r_since [NUM_POPS];
    logic [31:0]           r_wait  [NUM_POPS];
    logic                  r_halted;

    // item and walk
    t_in_item      r_item;
    logic [PW-1:0] r_recv;
    logic [2:0]    r_wk, r_pk, r_sel_k;
    logic [PW-1:0] r_wp, r_pp, r_sel_p;
    logic          r_walk_end, r_pv, r_found, r_selmode;
    logic [63:0]   r_prod, r_acc, r_tot, r_tgt;

    // divider
    logic [47:0]   r_dvd, r_quo;
    logic [63:0]   r_dvs, r_rem;
    logic [5:0]    r_dcnt;
    logic          r_dmode;

    // results
    logic [31:0]   r_soj, r_add;
    logic          r_full, r_ign;
    logic [18:0]   r_sum;
    logic          r_sum_end;
    logic          r_ovalid;
    t_out_item     r_out;

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // target index modulo the population count, narrow value
    function automatic logic [PW-1:0] pop_mod(input logic [2:0] t);
        logic [6:0] v;
        v = {4'b0, t};
        for (int k = 0; k < 8; k++) begin
            if (v >= 7'(NUM_POPS)) v = v - 7'(NUM_POPS);
        end
        return PW'(v);
    endfunction

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] rate;

    always_comb begin
        unique case (r_wk)
            KIND_EMIG:  rate = i_cfg.emigration_rate;
            KIND_BIRTH: rate = i_cfg.birth_rate;
            KIND_DEATH: rate = i_cfg.death_rate;
            KIND_SPEC:  rate = i_cfg.speciation_rate;
            default:    rate = i_cfg.immigration_rate;
        endcase
        if (i_cmd.op == OP_TGT0) begin
            mul_a = r_acc[31:0];
            mul_b = r_item.event_draw;
        end else if (i_cmd.op == OP_TGT1) begin
            mul_a = r_acc[63:32];
            mul_b = r_item.event_draw;
        end else if (r_wk == KIND_IMM) begin
            mul_a = 32'd1;
            mul_b = rate;
        end else begin
            mul_a = 32'(r_cnt[r_wp]);
            mul_b = rate;
        end
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // walk accumulate and hit test
    logic [63:0] acc_n;
    logic        hit;
    assign acc_n = sat64(r_acc, r_prod);
    assign hit   = r_selmode && !r_found && (r_pk != KIND_IMM) && (acc_n > r_tgt);

    // divider step
    logic [64:0] rem_sh;
    logic        dge;
    logic [63:0] rem_n;
    logic [47:0] quo_n;
    assign rem_sh = {r_rem, r_dvd[47]};
    assign dge    = (rem_sh >= {1'b0, r_dvs});
    assign rem_n  = dge ? 64'(rem_sh - {1'b0, r_dvs}) : rem_sh[63:0];
    assign quo_n  = {r_quo[46:0], dge};

    // abundance walk
    logic [32:0] sum_n;
    assign sum_n = 33'(r_sum) + 33'(r_cnt[r_wp]);

    logic migrant;
    assign migrant = (r_sel_k == KIND_EMIG) || (r_sel_k == KIND_IMM);

    // end-of-event checks, all populations side by side
    logic [COUNT_BITS-1:0] cnt_r;
    logic [COUNT_BITS-1:0] cnt_p;
    logic                  full;
    assign cnt_r = r_cnt[r_recv];
    assign cnt_p = r_cnt[r_sel_p];

    always_comb begin
        full = 1'b0;
        for (int j = 0; j < NUM_POPS; j++) begin
            if (r_cnt[j] != '0 && r_since[j] > r_wait[j]) full = 1'b1;
        end
    end

    assign o_sts.restart   = r_item.command;
    assign o_sts.halted    = r_halted;
    assign o_sts.walk_done = r_walk_end && !r_pv;
    assign o_sts.tot_zero  = (r_acc == 64'd0);
    assign o_sts.div_done  = (r_dcnt == 6'd1);
    assign o_sts.need_sdiv = migrant && (r_since[r_recv] != 32'd0) && i_cfg.setback_by_count
                             && (cnt_r != '0);
    assign o_sts.sum_done  = r_sum_end;
    assign o_sts.out_free  = !r_ovalid || !i_out_stall;

    // state arrays and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_POPS; j++) begin
                r_cnt[j]   <= '0;
                r_since[j] <= '0;
                r_wait[j]  <= WAIT_RESET;
            end
            r_halted <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_RESTART: begin
                    for (int j = 0; j < NUM_POPS; j++) begin
                        r_cnt[j]   <= '0;
                        r_since[j] <= '0;
                        r_wait[j]  <= i_cfg.initial_wait;
                    end
                    r_halted <= 1'b0;
                end
                OP_ADV: begin
                    for (int j = 0; j < NUM_POPS; j++) begin
                        if (r_since[j] != 32'd0) r_since[j] <= sat32(r_since[j], r_soj);
                    end
                end
                OP_EVT: begin
                    if (migrant) begin
                        if (cnt_r != CNT_MAX) r_cnt[r_recv] <= cnt_r + 1'b1;
                    end else if (r_sel_k == KIND_BIRTH) begin
                        if (cnt_p != CNT_MAX) r_cnt[r_sel_p] <= cnt_p + 1'b1;
                    end else if (r_sel_k == KIND_DEATH) begin
                        if (cnt_p != '0) r_cnt[r_sel_p] <= cnt_p - 1'b1;
                    end else begin
                        if (r_since[r_sel_p] == 32'd0) r_since[r_sel_p] <= r_soj;
                    end
                end
                OP_SETB: begin
                    if (migrant && r_since[r_recv] != 32'd0) begin
                        r_wait[r_recv] <= sat32(r_wait[r_recv], r_add);
                    end
                end
                OP_FIN: begin
                    for (int j = 0; j < NUM_POPS; j++) begin
                        if (r_cnt[j] == '0) begin
                            r_wait[j]  <= i_cfg.initial_wait;
                            r_since[j] <= '0;
                        end
                    end
                    if (full) r_halted <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_item <= i_in_item;
                r_recv <= pop_mod(i_in_item.target_draw);
            end
            OP_RESTART, OP_HALTED: begin
                r_soj   <= '0;
                r_sel_k <= KIND_EMIG;
                r_sel_p <= '0;
                r_full  <= 1'b0;
                r_ign   <= (i_cmd.op == OP_HALTED);
            end
            OP_WALK_INIT: begin
                r_wk       <= KIND_EMIG;
                r_wp       <= '0;
                r_walk_end <= 1'b0;
                r_pv       <= 1'b0;
                r_acc      <= '0;
                r_found    <= 1'b0;
                r_selmode  <= i_cmd.sel_mode;
                r_sel_k    <= KIND_IMM;
                r_sel_p    <= '0;
                r_ign      <= 1'b0;
                r_full     <= 1'b0;
            end
            OP_WALK: begin
                if (!r_walk_end) begin
                    r_prod <= mul_p;
                    r_pk   <= r_wk;
                    r_pp   <= r_wp;
                    r_pv   <= 1'b1;
                    if (r_wk == KIND_IMM) begin
                        r_walk_end <= 1'b1;
                    end else if (r_wp == LAST_POP) begin
                        r_wp <= '0;
                        r_wk <= r_wk + 3'd1;
                    end else begin
                        r_wp <= r_wp + 1'b1;
                    end
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= acc_n;
                    if (hit) begin
                        r_found <= 1'b1;
                        r_sel_k <= r_pk;
                        r_sel_p <= r_pp;
                    end
                end
            end
            OP_ZERO_SOJ: r_soj <= 32'hFFFF_FFFF;
            OP_TGT0: begin
                r_tot <= r_acc;
                r_tgt <= {32'b0, mul_p[63:32]};
            end
            OP_TGT1: r_prod <= mul_p;
            OP_TGT2: r_tgt  <= r_tgt + r_prod;
            OP_DIV_SOJ: begin
                r_dvd   <= {r_item.exp_draw, 16'b0};
                r_dvs   <= r_tot;
                r_rem   <= '0;
                r_quo   <= '0;
                r_dcnt  <= DIV_STEPS;
                r_dmode <= 1'b0;
            end
            OP_DIV_SETB: begin
                r_dvd   <= {16'b0, i_cfg.setback};
                r_dvs   <= 64'(cnt_r);
                r_rem   <= '0;
                r_quo   <= '0;
                r_dcnt  <= DIV_STEPS;
                r_dmode <= 1'b1;
            end
            OP_DIV: begin
                r_rem  <= rem_n;
                r_quo  <= quo_n;
                r_dvd  <= {r_dvd[46:0], 1'b0};
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd1) begin
                    if (r_dmode) begin
                        r_add <= quo_n[31:0];
                    end else begin
                        r_soj <= (quo_n[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_n[31:0];
                    end
                end
            end
            OP_EVT:  r_add  <= i_cfg.setback;
            OP_FIN:  r_full <= full;
            OP_SUM_INIT: begin
                r_wp      <= '0;
                r_sum     <= '0;
                r_sum_end <= 1'b0;
            end
            OP_SUM: begin
                if (!r_sum_end) begin
                    r_sum <= (sum_n > 33'(ABUND_MAX)) ? ABUND_MAX : sum_n[18:0];
                    if (r_wp == LAST_POP) begin
                        r_sum_end <= 1'b1;
                    end else begin
                        r_wp <= r_wp + 1'b1;
                    end
                end
            end
            OP_OUT: begin
                r_out.total_abundance  <= r_sum;
                r_out.sojourn_time     <= r_soj;
                r_out.event_kind       <= r_sel_k;
                r_out.event_population <= 3'(r_sel_p);
                r_out.full_speciation  <= r_full;
                r_out.ignored          <= r_ign;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== sv/gillespie_speciation_step_top.sv =====
// Top level of the Gillespie speciation step: APB register bank, sequencer, datapath.
// Depends on gss_pkg, gss_ctrl and gss_dp.
//
// Use: one input beat on the in channel (i_in_valid / o_in_stall, payload
// i_in_item) runs one stochastic event; one result beat leaves on the out
// channel (o_out_valid / i_out_stall, payload o_out_item). command 1 restarts
// the replicate, command 0 simulates one event, ignored (flagged) once a
// population has completed speciation.
// An event runs two walks over the 4*NUM_POPS+1 weights through the one shared
// multiplier and a 48-step restoring divide for the sojourn time; a migrant
// into an incipient population with divided setback adds a further 48-step
// divide; a zero total rate skips the selection and the divide. Restart and
// ignored steps skip the walks and go straight to the abundance sum.
// Flow: one item in flight; o_in_stall is high from acceptance until the
// result is in the output register, and only then is the next beat taken.
// The output register lets it be accepted while the last result waits.
// A stalled result holds steady and the block waits before writing the next one.
// Reset (synchronous, i_rst_n low) clears counts and clocks, loads every wait
// with 1.0 and sets the registers to their reset values; write them only when idle.
`default_nettype none
module gillespie_speciation_step_top #(
    parameter int NUM_POPS   = gss_pkg::NUM_POPS_DEF,
    parameter int COUNT_BITS = gss_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gss_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gss_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register bank, index from paddr word bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.birth_rate       <= '0;
            r_cfg.death_rate       <= '0;
            r_cfg.emigration_rate  <= '0;
            r_cfg.speciation_rate  <= '0;
            r_cfg.immigration_rate <= IMM_RESET;
            r_cfg.initial_wait     <= WAIT_RESET;
            r_cfg.setback          <= '0;
            r_cfg.setback_by_count <= 1'b0;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_BIRTH: r_cfg.birth_rate       <= pwdata;
                REG_DEATH: r_cfg.death_rate       <= pwdata;
                REG_EMIG:  r_cfg.emigration_rate  <= pwdata;
                REG_SPEC:  r_cfg.speciation_rate  <= pwdata;
                REG_IMM:   r_cfg.immigration_rate <= pwdata;
                REG_WAIT:  r_cfg.initial_wait     <= pwdata;
                REG_SETB:  r_cfg.setback          <= pwdata;
                REG_SCALE: r_cfg.setback_by_count <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_BIRTH: prdata = r_cfg.birth_rate;
            REG_DEATH: prdata = r_cfg.death_rate;
            REG_EMIG:  prdata = r_cfg.emigration_rate;
            REG_SPEC:  prdata = r_cfg.speciation_rate;
            REG_IMM:   prdata = r_cfg.immigration_rate;
            REG_WAIT:  prdata = r_cfg.initial_wait;
            REG_SETB:  prdata = r_cfg.setback;
            REG_SCALE: prdata = {31'b0, r_cfg.setback_by_count};
            default:   prdata = '0;
        endcase
    end

    // sequencer: accepts a beat only when idle
    gss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: state, multiplier, divider, result register
    gss_dp #(
        .NUM_POPS   (NUM_POPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== sv/gss_checker.sv =====
// Port-level checks for the Gillespie speciation step, bound to the top level.
// Depends on gss_pkg and gillespie_speciation_step_top_macros.svh.
`default_nettype none
`include "gillespie_speciation_step_top_macros.svh"
module gss_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gss_pkg::t_out_item o_out_item
);
    import gss_pkg::*;

    // one item at a time: busy right after a beat is taken
    `GSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a stalled result holds
    `GSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // ignored steps carry only the abundance
    `GSS_ASSERT_NOW(a_ignored_clean, o_out_valid && o_out_item.ignored, o_out_item.sojourn_time == 32'd0 && !o_out_item.full_speciation && o_out_item.event_kind == KIND_EMIG)

    // immigration reports population 0
    `GSS_ASSERT_NOW(a_imm_pop_zero, o_out_valid && o_out_item.event_kind == KIND_IMM, o_out_item.event_population == 3'd0)

endmodule

bind gillespie_speciation_step_top gss_checker u_gss_checker (.*);
`default_nettype wire
